>>> src/gwm_pkg.sv
package gwm_pkg;

    // Default pattern storage depth in bytes
    localparam int PATTERN_CAPACITY_DEF = 64;

    // Wildcard bytes
    localparam logic [7:0] STAR_BYTE     = 8'h2A;
    localparam logic [7:0] QUESTION_BYTE = 8'h3F;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_SUBJECT = 2'd2,
        REQ_END     = 2'd3
    } t_req;

    // Input beat
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_value;
    } t_in;

    // Output beat
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic       restart;   // back to position zero only
        logic       step;      // advance on a subject byte
        logic       append;    // store a pattern byte (already gated by full)
        logic [7:0] char_value;
    } t_cell_ctl;

endpackage

>>> src/gwm_cell.sv
module gwm_cell #(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gwm_pkg::t_cell_ctl i_ctl,
    input  logic [LW-1:0]      i_len,
    input  logic               i_closed,   // this position after star closure
    input  logic               i_adv,      // advance handed in from position IDX-1
    output logic               o_active,   // stored bit, before closure
    output logic               o_star,     // position holds a live '*'
    output logic               o_adv       // advance handed to position IDX+1
);
    import gwm_pkg::*;

    localparam logic [LW-1:0] IDX_L = LW'(IDX);

    logic [7:0] r_byte;
    logic       r_active;
    logic       n_active;
    logic       w_used;
    logic       w_is_star;
    logic       w_hit;

    // Position decode and byte compare
    assign w_used    = IDX_L < i_len;
    assign w_is_star = r_byte == STAR_BYTE;
    assign w_hit     = (r_byte == QUESTION_BYTE) || (r_byte == i_ctl.char_value);

    assign o_star   = w_used && w_is_star;
    assign o_adv    = i_closed && w_used && !w_is_star && w_hit;
    assign o_active = r_active;

    // On a step: a closed star stays set, any cell takes the neighbor's advance
    always_comb begin
        n_active = r_active;
        if (i_ctl.restart) begin
            n_active = (IDX == 0);
        end else if (i_ctl.step) begin
            n_active = (i_closed && o_star) || i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (IDX == 0);
        end else begin
            r_active <= n_active;
        end
    end

    // Pattern byte store, written when this is the next free slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (i_len == IDX_L)) begin
            r_byte <= i_ctl.char_value;
        end
    end

endmodule

>>> src/glob_wildcard_match.sv
// A result beat is registered when its end-of-subject beat is accepted and appears in the cycle after.
// Throughput: one beat per cycle of any kind; input stalls only while a result waits.
// The per-cycle path is the star closure, a carry chain across the whole cell row.
// Reset (synchronous, active low): empty pattern, overflow clear, position zero active,
// no result pending. Pattern bytes are not cleared.
module glob_wildcard_match #(
    parameter int PATTERN_CAPACITY = gwm_pkg::PATTERN_CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  gwm_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output gwm_pkg::t_out o_out_data
);
    import gwm_pkg::*;

    localparam int N  = PATTERN_CAPACITY;
    localparam int LW = $clog2(N + 1);

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_ovf;
    logic          n_ovf;
    logic          r_out_valid;
    t_out          r_out;

    logic          w_accept;
    logic          w_full;
    t_req          w_req;
    t_cell_ctl     w_ctl;

    logic [N:0]    w_act;
    logic [N:0]    w_star;
    logic [N:0]    w_sum;
    logic [N:0]    w_closed;
    logic [N+1:0]  w_adv;

    // Handshake: take a beat unless a result is stuck at the output
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = r_len == LW'(N);
    assign w_req      = t_req'(i_in_data.req_type);

    // Request decode
    always_comb begin
        w_ctl            = '0;
        w_ctl.char_value = i_in_data.char_value;
        n_len            = r_len;
        n_ovf            = r_ovf;
        if (w_accept) begin
            unique case (w_req)
                REQ_CLEAR: begin
                    w_ctl.restart = 1'b1;
                    n_len         = '0;
                    n_ovf         = 1'b0;
                end
                REQ_PATTERN: begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_ctl.append = 1'b1;
                        n_len        = r_len + LW'(1);
                    end
                end
                REQ_SUBJECT: begin
                    w_ctl.step = 1'b1;
                end
                REQ_END: begin
                    w_ctl.restart = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Star closure: a run of live stars passes an active bit through to the
    // position after the run, done as one carry chain
    assign w_sum    = (w_act & w_star) + w_star;
    assign w_closed = w_act | (w_sum ^ w_star);

    // Row of N+1 cells, one per position; the cell at the pattern length is the accept position
    assign w_adv[0] = 1'b0;

    for (genvar g = 0; g <= N; g++) begin : g_cell
        gwm_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_len    (r_len),
            .i_closed (w_closed[g]),
            .i_adv    (w_adv[g]),
            .o_active (w_act[g]),
            .o_star   (w_star[g]),
            .o_adv    (w_adv[g+1])
        );
    end

    // Pattern length and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && (w_req == REQ_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_req == REQ_END)) begin
            r_out.matched          <= w_closed[r_len];
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/gwm_checker.sv
module gwm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input gwm_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input gwm_pkg::t_out o_out_data
);
    import gwm_pkg::*;

    logic w_acc;
    logic w_acc_end;
    logic w_acc_clear;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_acc_end   = w_acc && (i_in_data.req_type == REQ_END);
    assign w_acc_clear = w_acc && (i_in_data.req_type == REQ_CLEAR);

    // Nothing pending coming out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    // Every accepted end of subject yields a result beat next cycle
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_end |=> o_out_valid)
        else $error("end of subject gave no result");

    // No result appears without an end of subject
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) && !w_acc_end |=> !o_out_valid)
        else $error("result beat without end of subject");

    // Empty pattern against empty subject matches, with no overflow
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_clear ##1 w_acc_end |=> o_out_data.matched && !o_out_data.pattern_overflow)
        else $error("empty pattern and subject did not match");

    // A held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

endmodule

bind glob_wildcard_match gwm_checker u_gwm_checker (.*);
